// File: hdl/aes_pkg.sv
// Package for the AES block cipher core: payload and config types, S-boxes,
// and GF(2^8) helpers. No dependencies.
`default_nettype none
package aes_pkg;

	typedef struct packed {
		logic        func;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} aes_out_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd4;

	localparam int unsigned RK_DEPTH = 60;
	localparam int unsigned RK_AW    = 6;

	localparam logic [7:0] GF_POLY = 8'h1b;

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage
`default_nettype wire

// File: hdl/aes_round.sv
// One AES round datapath (encrypt or decrypt), shared by every iteration.
// Depends on aes_pkg.
`default_nettype none
module aes_round (
	input  wire logic         inverse,
	input  wire logic         last,
	input  wire logic [127:0] state_in,
	input  wire logic [127:0] round_key,
	output logic      [127:0] state_out
);
	import aes_pkg::*;

	logic [7:0] s   [16];
	logic [7:0] t   [16];
	logic [7:0] u   [16];
	logic [7:0] v   [16];
	logic [7:0] k   [16];
	logic [7:0] m   [16];

	// Byte i of the block sits at bits 127-8i; row i%4, column i/4.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[127-8*i -: 8];
			k[i] = round_key[127-8*i -: 8];
		end
		// Forward: SubBytes then ShiftRows. Inverse: InvShiftRows then InvSubBytes.
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!inverse) begin
					t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
				end else begin
					t[4*c+r] = INV_SBOX[s[4*((c+4-r)%4)+r]];
				end
			end
		end
		// Forward: mix then add key. Inverse: add key then inverse mix. Last round: add key only.
		for (int i = 0; i < 16; i++) u[i] = inverse ? (t[i] ^ k[i]) : t[i];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!inverse) begin
					m[4*c+r] = gmul(8'd2, u[4*c+r]) ^ gmul(8'd3, u[4*c+(r+1)%4])
						^ u[4*c+(r+2)%4] ^ u[4*c+(r+3)%4];
				end else begin
					m[4*c+r] = gmul(8'd14, u[4*c+r]) ^ gmul(8'd11, u[4*c+(r+1)%4])
						^ gmul(8'd13, u[4*c+(r+2)%4]) ^ gmul(8'd9, u[4*c+(r+3)%4]);
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (last) begin
				v[i] = t[i] ^ k[i];
			end else if (inverse) begin
				v[i] = m[i];
			end else begin
				v[i] = m[i] ^ k[i];
			end
		end
		for (int i = 0; i < 16; i++) state_out[127-8*i -: 8] = v[i];
	end
endmodule
`default_nettype wire

// File: hdl/aes_block_cipher_core.sv
// AES-128/192/256 ECB core: key schedule sequencer, round-key memory, round unit.
// Depends on aes_pkg and aes_round.
// Each item steps through ST_RKRD, ST_INIT, ST_ROUND, ST_OUT: one round of the
// shared round unit per cycle, round keys read in order from round-key memory.
// The core takes no new item until the previous result has left and it is idle
// again. After reset or a write to a config register, the first item first
// expands the schedule, one key word per cycle (44, 52 or 60 words). Reset
// clears control state and the config registers only.
`default_nettype none
module aes_block_cipher_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire aes_pkg::aes_in_t                   in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output aes_pkg::aes_out_t                       out_data,
	input  wire logic                               cfg_we,
	input  wire logic [aes_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [63:0]                        cfg_data
);
	import aes_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_KEXP  = 6'b000010,
		ST_RKRD  = 6'b000100,
		ST_INIT  = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t        state_q;
	logic [1:0]    key_mode_q;
	logic [63:0]   key_word_q [4];
	logic          sched_ok_q;
	logic          func_q;
	logic [127:0]  blk_q;
	logic [3:0]    round_q;
	logic [RK_AW-1:0] kidx_q;
	logic [31:0]   win_q [8];
	logic [7:0]    rcon_q;
	logic [2:0]    wcnt_q;
	logic [3:0]    rd_addr;
	logic [127:0]  rk_rd_q;
	logic [127:0]  rk_mem [RK_DEPTH/4];

	logic [1:0]    mode_sat;
	logic [3:0]    nk;
	logic [3:0]    nr;
	logic [RK_AW-1:0] total;
	logic [31:0]   new_w;
	logic [31:0]   tw;
	logic [127:0]  rnd_out;
	logic          rnd_last;
	logic [3:0]    next_round;

	assign mode_sat = (key_mode_q == 2'd3) ? 2'd2 : key_mode_q;
	assign nk    = 4'd4 + {1'b0, mode_sat, 1'b0};
	assign nr    = 4'd10 + {1'b0, mode_sat, 1'b0};
	assign total = {nr[3:0], 2'b00} + RK_AW'(4);

	// Key expansion: win_q holds the last nk words; kidx_q counts words,
	// wcnt_q is kidx mod nk from kidx = nk on.
	always_comb begin
		tw = win_q[nk[2:0] - 3'd1];
		if (wcnt_q == 3'd0) begin
			tw = sub_word({tw[23:0], tw[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && wcnt_q == 3'd4) begin
			tw = sub_word(tw);
		end
		new_w = win_q[0] ^ tw;
	end

	// Round keys in memory: row r is round r's four words.
	logic [127:0] row_acc_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_KEXP && kidx_q[1:0] == 2'd3) begin
			rk_mem[kidx_q[RK_AW-1:2]] <= {row_acc_q[95:0], (kidx_q < RK_AW'(nk))
				? win_q[kidx_q[2:0]] : new_w};
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	// The round key is registered in rk_rd_q ahead of the round that uses it.
	assign next_round = func_q ? (round_q - 4'd1) : (round_q + 4'd1);
	always_comb begin
		if (state_q == ST_ROUND && !rnd_last) begin
			rd_addr = func_q ? (round_q - 4'd2) : (round_q + 4'd2);
		end else if (state_q == ST_ROUND || state_q == ST_INIT) begin
			rd_addr = next_round;
		end else begin
			rd_addr = func_q ? nr : 4'd0;
		end
	end

	assign rnd_last = func_q ? (round_q == 4'd1) : (round_q == nr - 4'd1);

	aes_round u_round (
		.inverse   (func_q),
		.last      (rnd_last),
		.state_in  (blk_q),
		.round_key (rk_rd_q),
		.state_out (rnd_out)
	);

	assign in_stall  = (state_q != ST_IDLE) || cfg_we;
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = '{result_hi: blk_q[127:64], result_lo: blk_q[63:0]};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= 2'd0;
			for (int i = 0; i < 4; i++) key_word_q[i] <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_MODE:  key_mode_q    <= cfg_data[1:0];
				REG_KEY_WORD0: key_word_q[0] <= cfg_data;
				REG_KEY_WORD1: key_word_q[1] <= cfg_data;
				REG_KEY_WORD2: key_word_q[2] <= cfg_data;
				REG_KEY_WORD3: key_word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sched_ok_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index <= REG_KEY_WORD3) sched_ok_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= sched_ok_q ? ST_RKRD : ST_KEXP;
					end
				end
				ST_KEXP: begin
					if (kidx_q == total - RK_AW'(1)) begin
						state_q    <= ST_RKRD;
						sched_ok_q <= 1'b1;
					end
				end
				ST_RKRD:  state_q <= ST_INIT;
				ST_INIT:  state_q <= ST_ROUND;
				ST_ROUND: if (rnd_last) state_q <= ST_OUT;
				ST_OUT:   if (!out_stall) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= in_data.func;
				blk_q  <= {in_data.block_hi, in_data.block_lo};
				kidx_q <= '0;
				wcnt_q <= 3'd0;
				rcon_q <= 8'h01;
				for (int i = 0; i < 4; i++) begin
					win_q[2*i]   <= key_word_q[i][63:32];
					win_q[2*i+1] <= key_word_q[i][31:0];
				end
			end
			ST_KEXP: begin
				row_acc_q <= {row_acc_q[95:0], (kidx_q < RK_AW'(nk))
					? win_q[kidx_q[2:0]] : new_w};
				kidx_q <= kidx_q + RK_AW'(1);
				if (kidx_q >= RK_AW'(nk) - RK_AW'(1)) begin
					if (kidx_q >= RK_AW'(nk)) begin
						// Slide the window down one word; the new word enters at nk-1.
						for (int i = 0; i < 7; i++) begin
							win_q[i] <= (4'(i) == nk - 4'd1) ? new_w : win_q[i+1];
						end
						win_q[7] <= (nk == 4'd8) ? new_w : win_q[7];
						if (wcnt_q == 3'd0) rcon_q <= xtime(rcon_q);
					end
					wcnt_q <= (wcnt_q == nk[2:0] - 3'd1 || kidx_q == RK_AW'(nk) - RK_AW'(1))
						? 3'd0 : wcnt_q + 3'd1;
				end
			end
			ST_RKRD: round_q <= func_q ? nr : 4'd0;
			ST_INIT: blk_q <= blk_q ^ rk_rd_q;
			ST_ROUND: begin
				blk_q   <= rnd_out;
				round_q <= next_round;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
